// ----- hw/rtl/fspe_pkg.sv -----
// Shared types and codes of the filtered shortest path engine.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package fspe_pkg;

  localparam logic [1:0] MODE_ADD_NODE = 2'd0;
  localparam logic [1:0] MODE_ADD_EDGE = 2'd1;
  localparam logic [1:0] MODE_SET_EN   = 2'd2;
  localparam logic [1:0] MODE_QUERY    = 2'd3;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LATCH,
    CMD_ADD_NODE,
    CMD_ADD_EDGE,
    CMD_EN_READ,
    CMD_EN_WRITE,
    CMD_SWEEP,
    CMD_Q_INIT,
    CMD_NOPATH,
    CMD_SCAN,
    CMD_SCAN_INIT,
    CMD_SETTLE,
    CMD_P_START,
    CMD_E_RD,
    CMD_E_CHK,
    CMD_E_UPD,
    CMD_P_PUSH,
    CMD_P_PRED,
    CMD_EMIT_RD,
    CMD_EMIT_OUT
  } cmd_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ADD_NODE,
    S_ADD_EDGE,
    S_EN_RD,
    S_EN_WR,
    S_SWEEP,
    S_Q_INIT,
    S_NOPATH,
    S_SCAN,
    S_SETTLE,
    S_PATH_CHK,
    S_E_RD,
    S_E_CHK,
    S_E_UPD,
    S_P_PUSH,
    S_P_PRED,
    S_EMIT_RD,
    S_EMIT_OUT
  } state_t;

  typedef struct packed {
    logic out_free;
    logic sweep_last;
    logic ends_ok;
    logic scan_last;
    logic found;
    logic cur_is_goal;
    logic goal_reached;
    logic edge_end;
    logic edge_qual;
    logic path_more;
    logic emit_last;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/filtered_shortest_path_engine.sv -----
// Top level of the filtered shortest path engine: controller plus datapath.
// Depends on fspe_pkg, fspe_ctrl and fspe_dp.
//
// The input channel (in_valid/in_ready) takes one item at a time; in_ready is
// high only while the engine is idle. Add node and add edge load their one
// result once the output register is free and then return to idle; an enable
// change first reads the node memory in a state of its own.
// A path query first sweeps the node memory to build the traversable set.
// Each settled node then costs a minimum scan over the distance memory and a
// pass over every stored edge, with a distance read and a possible update for
// each usable edge that leaves the settled node. The path is then walked back
// from the goal and emitted start first.
// Results leave through an output register (out_valid/out_ready); while the
// receiver stalls, the engine holds at the next result it would load.
// Synchronous reset empties the graph, clears the revision counter and the
// edge count; no memory clearing pass is needed.
`default_nettype none

module filtered_shortest_path_engine
  import fspe_pkg::*;
#(
  parameter int MAX_NODES = 64,
  parameter int MAX_EDGES = 256,
  parameter int COST_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  mode,
  input  wire logic [5:0]  node_id,
  input  wire logic [5:0]  other_node,
  input  wire logic        enable_flag,
  input  wire logic [31:0] required_caps,
  input  wire logic [31:0] access_needs,
  input  wire logic [15:0] edge_cost,
  input  wire logic [31:0] held_caps,
  input  wire logic [31:0] held_access,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             accepted,
  output logic             reachable,
  output logic [5:0]       path_node,
  output logic             last,
  output logic [31:0]      revision
);

  cmd_t       cmd;
  dp_status_t status;

  fspe_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .mode, .status, .cmd
  );

  fspe_dp #(
    .MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES), .COST_BITS(COST_BITS)
  ) u_dp (
    .clk, .rst, .cmd, .status, .node_id, .other_node, .enable_flag,
    .required_caps, .access_needs, .edge_cost, .held_caps, .held_access,
    .out_valid, .out_ready, .accepted, .reachable, .path_node, .last, .revision
  );

endmodule

`default_nettype wire

// ----- hw/rtl/fspe_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module fspe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/fspe_dp.sv -----
// Datapath of the filtered shortest path engine: graph storage, search state,
// path stack and the output register. Depends on fspe_pkg and fspe_ram.
`default_nettype none

module fspe_dp
  import fspe_pkg::*;
#(
  parameter int MAX_NODES = 64,
  parameter int MAX_EDGES = 256,
  parameter int COST_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cmd_t        cmd,
  output dp_status_t       status,
  input  wire logic [5:0]  node_id,
  input  wire logic [5:0]  other_node,
  input  wire logic        enable_flag,
  input  wire logic [31:0] required_caps,
  input  wire logic [31:0] access_needs,
  input  wire logic [15:0] edge_cost,
  input  wire logic [31:0] held_caps,
  input  wire logic [31:0] held_access,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             accepted,
  output logic             reachable,
  output logic [5:0]       path_node,
  output logic             last,
  output logic [31:0]      revision
);

  localparam int NW = $clog2(MAX_NODES);
  localparam int EW = $clog2(MAX_EDGES);
  localparam int DW = COST_BITS + 6;
  localparam int NODE_W = 65;
  localparam int EDGE_W = 2 * NW + COST_BITS + 1;
  localparam int DIST_W = DW + NW;

  logic [5:0]           a_id, b_id;
  logic                 flag;
  logic [31:0]          caps_req, acc_req, cap_mask, acc_mask;
  logic [COST_BITS-1:0] cost;

  logic [MAX_NODES-1:0] present, pass, reached, settled;
  logic [EW:0]          edge_count, eidx;
  logic [31:0]          revision_count;
  logic [NW:0]          sidx, qidx, n;
  logic                 pvalid, found;
  logic [NW-1:0]        pidx, cur, v;
  logic [DW-1:0]        cur_dist;

  logic              n_we, n_re;
  logic [NW-1:0]     n_waddr, n_raddr;
  logic [NODE_W-1:0] n_wdata, n_rd;
  logic              e_we, e_re;
  logic [EW-1:0]     e_waddr, e_raddr;
  logic [EDGE_W-1:0] e_wdata, e_rd;
  logic              d_we, d_re;
  logic [NW-1:0]     d_waddr, d_raddr;
  logic [DIST_W-1:0] d_wdata, d_rd;
  logic              s_we, s_re;
  logic [NW-1:0]     s_waddr, s_raddr;
  logic [NW-1:0]     s_wdata, s_rd;

  logic [NW-1:0]  a_ix, b_ix, psix;
  logic           a_ok, b_ok, node_ok, edge_ok, en_ok, sweep_pass, better, improve;
  logic           nd_en;
  logic [31:0]    nd_caps, nd_acc;
  logic [NW-1:0]  e_src, e_tgt, d_pred;
  logic [COST_BITS-1:0] e_w;
  logic           e_on;
  logic [DW-1:0]  d_dist, cand;
  logic           out_load, out_acc_n, out_reach_n, out_last_n;
  logic [5:0]     out_node_n;
  logic [31:0]    rev_n;

  fspe_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_node_ram (
    .clk, .we(n_we), .waddr(n_waddr), .wdata(n_wdata), .re(n_re), .raddr(n_raddr),
    .rdata(n_rd)
  );
  fspe_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk, .we(e_we), .waddr(e_waddr), .wdata(e_wdata), .re(e_re), .raddr(e_raddr),
    .rdata(e_rd)
  );
  fspe_ram #(.WIDTH(DIST_W), .DEPTH(MAX_NODES)) u_dist_ram (
    .clk, .we(d_we), .waddr(d_waddr), .wdata(d_wdata), .re(d_re), .raddr(d_raddr),
    .rdata(d_rd)
  );
  fspe_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_stack_ram (
    .clk, .we(s_we), .waddr(s_waddr), .wdata(s_wdata), .re(s_re), .raddr(s_raddr),
    .rdata(s_rd)
  );

  always_comb begin
    a_ix = a_id[NW-1:0];
    b_ix = b_id[NW-1:0];
    psix = NW'(sidx - 1'b1);
    a_ok = (a_id != '0) && (7'(a_id) < 7'(MAX_NODES));
    b_ok = (b_id != '0) && (7'(b_id) < 7'(MAX_NODES));
    nd_en   = n_rd[64];
    nd_caps = n_rd[63:32];
    nd_acc  = n_rd[31:0];
    e_src = e_rd[EDGE_W-1 -: NW];
    e_tgt = e_rd[EDGE_W-NW-1 -: NW];
    e_w   = e_rd[COST_BITS:1];
    e_on  = e_rd[0];
    d_dist = d_rd[DIST_W-1 -: DW];
    d_pred = d_rd[NW-1:0];
    cand = cur_dist + DW'(e_w);

    node_ok = a_ok && !present[a_ix];
    edge_ok = a_ok && b_ok && present[a_ix] && present[b_ix] && (cost != '0) &&
              (edge_count < (EW+1)'(MAX_EDGES));
    en_ok = a_ok && present[a_ix] && (nd_en != flag);
    sweep_pass = present[psix] && nd_en && ((nd_caps & ~cap_mask) == '0) &&
                 ((nd_acc & ~acc_mask) == '0);
    better = pvalid && reached[pidx] && !settled[pidx] && (!found || d_dist < cur_dist);
    improve = !reached[e_tgt] || (cand < d_dist) || ((cand == d_dist) && (cur < d_pred));

    status.out_free     = !out_valid || out_ready;
    status.sweep_last   = (sidx == (NW+1)'(MAX_NODES));
    status.ends_ok      = a_ok && b_ok && pass[a_ix] && pass[b_ix];
    status.scan_last    = (qidx == (NW+1)'(MAX_NODES));
    status.found        = found;
    status.cur_is_goal  = (cur == b_ix);
    status.goal_reached = reached[b_ix];
    status.edge_end     = (eidx >= edge_count);
    status.edge_qual    = e_on && (e_src == cur) && pass[e_tgt];
    status.path_more    = (v != a_ix) && ((n + 1'b1) < (NW+1)'(MAX_NODES));
    status.emit_last    = (n == (NW+1)'(1));

    n_we = 1'b0; n_waddr = a_ix; n_wdata = {flag, caps_req, acc_req};
    n_re = 1'b0; n_raddr = a_ix;
    e_we = 1'b0; e_waddr = edge_count[EW-1:0];
    e_wdata = {a_ix, b_ix, cost, flag};
    e_re = 1'b0; e_raddr = eidx[EW-1:0];
    d_we = 1'b0; d_waddr = a_ix; d_wdata = {DW'(0), NW'(0)};
    d_re = 1'b0; d_raddr = qidx[NW-1:0];
    s_we = 1'b0; s_waddr = n[NW-1:0]; s_wdata = v;
    s_re = 1'b0; s_raddr = NW'(n - 1'b1);
    out_load = 1'b0; out_acc_n = 1'b0; out_reach_n = 1'b0; out_last_n = 1'b1;
    out_node_n = '0; rev_n = revision_count;

    unique case (cmd)
      CMD_ADD_NODE: begin
        n_we = node_ok;
        out_load = 1'b1; out_acc_n = node_ok;
        rev_n = revision_count + 32'(node_ok);
      end
      CMD_ADD_EDGE: begin
        e_we = edge_ok;
        out_load = 1'b1; out_acc_n = edge_ok;
        rev_n = revision_count + 32'(edge_ok);
      end
      CMD_EN_READ: n_re = 1'b1;
      CMD_EN_WRITE: begin
        n_we = en_ok; n_wdata = {flag, nd_caps, nd_acc};
        out_load = 1'b1; out_acc_n = en_ok;
        rev_n = revision_count + 32'(en_ok);
      end
      CMD_SWEEP: begin
        n_re = (sidx < (NW+1)'(MAX_NODES)); n_raddr = sidx[NW-1:0];
      end
      CMD_Q_INIT: d_we = 1'b1;
      CMD_NOPATH: out_load = 1'b1;
      CMD_SCAN: d_re = (qidx < (NW+1)'(MAX_NODES));
      CMD_E_RD: e_re = 1'b1;
      CMD_E_CHK: begin
        d_re = 1'b1; d_raddr = e_tgt;
      end
      CMD_E_UPD: begin
        d_we = improve; d_waddr = e_tgt; d_wdata = {cand, cur};
      end
      CMD_P_PUSH: begin
        s_we = 1'b1;
        d_re = status.path_more; d_raddr = v;
      end
      CMD_EMIT_RD: s_re = 1'b1;
      CMD_EMIT_OUT: begin
        out_load = 1'b1; out_reach_n = 1'b1; out_last_n = status.emit_last;
        out_node_n = 6'(s_rd);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present <= '0;
      edge_count <= '0;
      revision_count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
        accepted  <= out_acc_n;
        reachable <= out_reach_n;
        path_node <= out_node_n;
        last      <= out_last_n;
        revision  <= rev_n;
        revision_count <= rev_n;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (cmd)
        CMD_LATCH: begin
          a_id <= node_id; b_id <= other_node; flag <= enable_flag;
          caps_req <= required_caps; acc_req <= access_needs;
          cost <= COST_BITS'(edge_cost);
          cap_mask <= held_caps; acc_mask <= held_access;
          sidx <= '0;
        end
        CMD_ADD_NODE: if (node_ok) present[a_ix] <= 1'b1;
        CMD_ADD_EDGE: if (edge_ok) edge_count <= edge_count + 1'b1;
        CMD_SWEEP: begin
          if (sidx != '0) pass[psix] <= sweep_pass;
          sidx <= sidx + 1'b1;
        end
        CMD_Q_INIT, CMD_SCAN_INIT: begin
          if (cmd == CMD_Q_INIT) begin
            reached <= MAX_NODES'(1) << a_ix;
            settled <= '0;
          end
          qidx <= (NW+1)'(1);
          pvalid <= 1'b0;
          found <= 1'b0;
        end
        CMD_SCAN: begin
          if (better) begin
            found <= 1'b1; cur <= pidx; cur_dist <= d_dist;
          end
          pvalid <= (qidx < (NW+1)'(MAX_NODES));
          pidx <= qidx[NW-1:0];
          qidx <= qidx + 1'b1;
        end
        CMD_SETTLE: begin
          settled[cur] <= 1'b1;
          eidx <= '0;
        end
        CMD_E_RD: eidx <= eidx + 1'b1;
        CMD_E_UPD: if (improve) reached[e_tgt] <= 1'b1;
        CMD_P_START: begin
          v <= b_ix; n <= '0;
        end
        CMD_P_PUSH: n <= n + 1'b1;
        CMD_P_PRED: v <= d_pred;
        CMD_EMIT_OUT: n <= n - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/fspe_ctrl.sv -----
// Controller state machine of the filtered shortest path engine.
// Depends on fspe_pkg; drives the datapath by commands and reads its status.
`default_nettype none

module fspe_ctrl
  import fspe_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] mode,
  input  wire dp_status_t status,
  output cmd_t            cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = CMD_NONE;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd = CMD_LATCH;
          unique case (mode)
            MODE_ADD_NODE: state_next = S_ADD_NODE;
            MODE_ADD_EDGE: state_next = S_ADD_EDGE;
            MODE_SET_EN:   state_next = S_EN_RD;
            MODE_QUERY:    state_next = S_SWEEP;
            default:       state_next = S_IDLE;
          endcase
        end
      end
      S_ADD_NODE: if (status.out_free) begin
        cmd = CMD_ADD_NODE; state_next = S_IDLE;
      end
      S_ADD_EDGE: if (status.out_free) begin
        cmd = CMD_ADD_EDGE; state_next = S_IDLE;
      end
      S_EN_RD: begin
        cmd = CMD_EN_READ; state_next = S_EN_WR;
      end
      S_EN_WR: if (status.out_free) begin
        cmd = CMD_EN_WRITE; state_next = S_IDLE;
      end
      S_SWEEP: begin
        cmd = CMD_SWEEP;
        if (status.sweep_last) state_next = S_Q_INIT;
      end
      S_Q_INIT: begin
        if (status.ends_ok) begin
          cmd = CMD_Q_INIT; state_next = S_SCAN;
        end else begin
          state_next = S_NOPATH;
        end
      end
      S_NOPATH: if (status.out_free) begin
        cmd = CMD_NOPATH; state_next = S_IDLE;
      end
      S_SCAN: begin
        cmd = CMD_SCAN;
        if (status.scan_last) state_next = S_SETTLE;
      end
      S_SETTLE: begin
        if (!status.found) begin
          state_next = S_PATH_CHK;
        end else begin
          cmd = CMD_SETTLE;
          state_next = status.cur_is_goal ? S_PATH_CHK : S_E_RD;
        end
      end
      S_PATH_CHK: begin
        if (status.goal_reached) begin
          cmd = CMD_P_START; state_next = S_P_PUSH;
        end else begin
          state_next = S_NOPATH;
        end
      end
      S_E_RD: begin
        if (status.edge_end) begin
          cmd = CMD_SCAN_INIT; state_next = S_SCAN;
        end else begin
          cmd = CMD_E_RD; state_next = S_E_CHK;
        end
      end
      S_E_CHK: begin
        if (status.edge_qual) begin
          cmd = CMD_E_CHK; state_next = S_E_UPD;
        end else begin
          state_next = S_E_RD;
        end
      end
      S_E_UPD: begin
        cmd = CMD_E_UPD; state_next = S_E_RD;
      end
      S_P_PUSH: begin
        cmd = CMD_P_PUSH;
        state_next = status.path_more ? S_P_PRED : S_EMIT_RD;
      end
      S_P_PRED: begin
        cmd = CMD_P_PRED; state_next = S_P_PUSH;
      end
      S_EMIT_RD: begin
        cmd = CMD_EMIT_RD; state_next = S_EMIT_OUT;
      end
      S_EMIT_OUT: if (status.out_free) begin
        cmd = CMD_EMIT_OUT;
        state_next = status.emit_last ? S_IDLE : S_EMIT_RD;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/fspe_checker.sv -----
// Port-level checker of the filtered shortest path engine and its bind.
// Depends on filtered_shortest_path_engine.
`default_nettype none

module fspe_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        accepted,
  input wire logic        reachable,
  input wire logic [5:0]  path_node,
  input wire logic        last,
  input wire logic [31:0] revision
);

  // A stalled result transfer keeps its valid, path node and revision.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(path_node) && $stable(revision))
    else $error("stalled result changed");

  // The engine takes one item at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  a_acc_reach: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(accepted && reachable))
    else $error("accepted and reachable together");

  a_multi: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> reachable)
    else $error("non-final result outside a path");

  a_no_node: assert property (@(posedge clk) disable iff (rst)
    out_valid && !reachable |-> path_node == 6'd0)
    else $error("path node without a path");

endmodule

bind filtered_shortest_path_engine fspe_checker u_fspe_checker (.*);

`default_nettype wire
